>>> rtl/obsp_pkg.sv
// ============================================================================
// obsp_pkg
// Shared widths, types and constants of the oriented box support point unit.
// ============================================================================
package obsp_pkg;

   // Field widths
   localparam int COORD_W  = 32;                 // Q16.16 coordinates
   localparam int QUAT_W   = 18;                 // Q1.16 quaternion parts
   localparam int QPROD_W  = 2 * QUAT_W;         // quaternion part products
   localparam int MSUM_W   = QPROD_W + 2;        // matrix entry before rounding
   localparam int MAT_W    = MSUM_W - 16;        // matrix entry, Q.16
   localparam int MPROD_W  = MAT_W + COORD_W;    // matrix entry times box bound
   localparam int ACC_W    = MPROD_W + 2;        // sum of three such products
   localparam int CRN_W    = ACC_W - 16 + 1;     // rotated corner plus position
   localparam int CLO_W    = 21;                 // low slice of a corner coordinate
   localparam int CHI_W    = CRN_W - CLO_W;      // high slice of a corner coordinate
   localparam int PLO_W    = COORD_W + CLO_W + 1;
   localparam int PHI_W    = COORD_W + CHI_W;
   localparam int TERM_W   = COORD_W + CRN_W;    // one axis of a dot product
   localparam int DOT_W    = TERM_W + 2;         // full dot product
   localparam int NUM_CRN  = 8;

   // Offset path
   localparam int MAG_W       = 32;
   localparam int SHIFT_W     = 5;
   localparam int NORM_MSB    = 30;              // largest magnitude is pushed to here
   localparam int SQ_W        = 64;
   localparam int ROOT_W      = 32;
   localparam int SQRT_REM_W  = ROOT_W + 3;
   localparam int SQRT_STEPS  = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
   localparam int QUOT_W      = 32;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = QUOT_W / DIV_STEPS;
   localparam int OFF_W       = QUOT_W + 2;
   localparam int SUM_W       = CRN_W + 1;

   // Pipeline depths, counted from the input register stage
   localparam int ROT_LAT = 4;
   localparam int SEL_LAT = 6;
   localparam int OFF_LAT = 5 + SQRT_STAGES + 1 + DIV_STAGES + 1;
   localparam int CRN_DLY = OFF_LAT - ROT_LAT - SEL_LAT;
   localparam int RSP_LAT = OFF_LAT + 2;          // accepting edge to strobe sample

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [MAT_W-1:0]   mat_type;
   typedef logic signed [CRN_W-1:0]   crn_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [OFF_W-1:0]   off_type;

   // Corner order: bit 0 picks max x, bit 1 max y, bit 2 max z
   localparam logic [2:0] CRN_SEL [NUM_CRN] = '{3'd0, 3'd1, 3'd2, 3'd4,
                                                3'd7, 3'd6, 3'd5, 3'd3};

   // Register map
   typedef enum logic [2:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   // Square root pipeline word
   typedef struct packed {
      logic [SQ_W-1:0]       n;
      logic [SQRT_REM_W-1:0] rem;
      logic [ROOT_W-1:0]     root;
   } sqrt_type;

   // Sideband carried along the square root
   typedef struct packed {
      logic                  zero;
      logic [2:0]            neg;
      logic [2:0][SQ_W-1:0]  prd;
   } sqrt_side_type;

   // One divider lane
   typedef struct packed {
      logic [QUOT_W-1:0] rem;
      logic [QUOT_W-1:0] q;
      logic [QUOT_W-1:0] nb;
   } div_type;

   // Sideband carried along the divider
   typedef struct packed {
      logic              zero;
      logic [2:0]        neg;
      logic [ROOT_W-1:0] len;
   } div_side_type;

endpackage

>>> rtl/oriented_box_support_point_unit.sv
// ============================================================================
// oriented_box_support_point_unit
// Support point of a rotated, translated box along a search direction,
// pushed out along the normalized direction by a bias distance.
// ============================================================================
// Usage:
//  - Box bounds are six registers on the csr_ port (index 0..5: min x/y/z,
//    max x/y/z). csr_ready is always high; indexes above five are dropped.
//    Write them only while no query is in flight.
//  - A query beat is taken on a rising edge with start high and busy low.
//    busy never rises, so a query may be issued on every cycle.
//  - Each query yields one result beat on rsp_strobe; queries come back in
//    issue order.
//  - Throughput is one query per cycle. Latency is set by the offset path:
//    16 square root stages at two root bits each, 8 divider stages at four
//    quotient bits each, plus input, setup and output registers. The corner
//    path (rotate then dot-product max tree) is delayed to meet it.
//  - The receiver has no stall: the result is on the rsp_ ports for the
//    one cycle that rsp_strobe is high.
//  - Synchronous reset clears the box registers to zero and drops every
//    query in flight.
// ============================================================================
module oriented_box_support_point_unit (
   input  logic               clock,
   input  logic               reset,
   // query channel
   input  logic               start,
   output logic               busy,
   input  obsp_pkg::coord_type req_dir_x,
   input  obsp_pkg::coord_type req_dir_y,
   input  obsp_pkg::coord_type req_dir_z,
   input  obsp_pkg::coord_type req_pos_x,
   input  obsp_pkg::coord_type req_pos_y,
   input  obsp_pkg::coord_type req_pos_z,
   input  obsp_pkg::quat_type  req_rot_w,
   input  obsp_pkg::quat_type  req_rot_x,
   input  obsp_pkg::quat_type  req_rot_y,
   input  obsp_pkg::quat_type  req_rot_z,
   input  obsp_pkg::coord_type req_bias,
   // result channel
   output logic               rsp_strobe,
   output obsp_pkg::coord_type rsp_point_x,
   output obsp_pkg::coord_type rsp_point_y,
   output obsp_pkg::coord_type rsp_point_z,
   output logic               rsp_saturated,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  obsp_pkg::coord_type csr_wdata
);
   import obsp_pkg::*;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // box registers
   coord_type box_lo_ff [3];
   coord_type box_hi_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_lo_ff[i] <= '0;
            box_hi_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_MIN_X: box_lo_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y: box_lo_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z: box_lo_ff[2] <= csr_wdata;
            CSR_BOX_MAX_X: box_hi_ff[0] <= csr_wdata;
            CSR_BOX_MAX_Y: box_hi_ff[1] <= csr_wdata;
            CSR_BOX_MAX_Z: box_hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register stage
   logic      req_accept;
   logic      s0_vld_ff;
   coord_type dir_ff [3];
   coord_type pos_ff [3];
   quat_type  rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   coord_type bias_ff;

   assign req_accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= req_accept;
      end
      if (req_accept) begin
         dir_ff   <= '{req_dir_x, req_dir_y, req_dir_z};
         pos_ff   <= '{req_pos_x, req_pos_y, req_pos_z};
         rot_w_ff <= req_rot_w;
         rot_x_ff <= req_rot_x;
         rot_y_ff <= req_rot_y;
         rot_z_ff <= req_rot_z;
         bias_ff  <= req_bias;
      end
   end

   // corner path
   logic      rot_vld;
   coord_type rot_dir [3];
   crn_type   rot_crn [NUM_CRN][3];
   logic      sel_vld;
   crn_type   sel_best [3];

   obsp_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_vld_ff),
      .dir_in    (dir_ff),
      .pos_in    (pos_ff),
      .rot_w     (rot_w_ff),
      .rot_x     (rot_x_ff),
      .rot_y     (rot_y_ff),
      .rot_z     (rot_z_ff),
      .box_lo    (box_lo_ff),
      .box_hi    (box_hi_ff),
      .out_valid (rot_vld),
      .dir_out   (rot_dir),
      .crn_out   (rot_crn)
   );

   obsp_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_vld),
      .dir_in    (rot_dir),
      .crn_in    (rot_crn),
      .out_valid (sel_vld),
      .best_out  (sel_best)
   );

   // offset path
   logic    off_vld;
   off_type off [3];

   obsp_offset u_offset (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_vld_ff),
      .dir_in    (dir_ff),
      .bias_in   (bias_ff),
      .out_valid (off_vld),
      .off_out   (off)
   );

   // align the chosen corner with the offset
   logic [CRN_DLY-1:0] dly_vld_ff;
   crn_type            dly_crn_ff [CRN_DLY][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else begin
         dly_vld_ff <= {dly_vld_ff[CRN_DLY-2:0], sel_vld};
      end
      dly_crn_ff[0] <= sel_best;
      for (int s = 1; s < CRN_DLY; s++) begin
         dly_crn_ff[s] <= dly_crn_ff[s-1];
      end
   end

   // add offset and saturate
   logic signed [SUM_W-1:0] sum [3];
   coord_type               pt_in [3];
   logic                    sat_in;
   coord_type               pt_ff [3];
   logic                    sat_ff, strobe_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sum[i] = SUM_W'(dly_crn_ff[CRN_DLY-1][i]) + SUM_W'(off[i]);
         if (!sum[i][SUM_W-1] && (sum[i][SUM_W-2:COORD_W-1] != '0)) begin
            pt_in[i] = {1'b0, {(COORD_W-1){1'b1}}};
            sat_in   = 1'b1;
         end else if (sum[i][SUM_W-1] && (sum[i][SUM_W-2:COORD_W-1] != '1)) begin
            pt_in[i] = {1'b1, {(COORD_W-1){1'b0}}};
            sat_in   = 1'b1;
         end else begin
            pt_in[i] = sum[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= off_vld;
      end
      pt_ff  <= pt_in;
      sat_ff <= sat_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_point_x   = pt_ff[0];
   assign rsp_point_y   = pt_ff[1];
   assign rsp_point_z   = pt_ff[2];
   assign rsp_saturated = sat_ff;

   // checks
   a_path_align: assert property (@(posedge clock) disable iff (reset)
      dly_vld_ff[CRN_DLY-1] == off_vld)
      else $error("corner and offset paths out of step");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, RSP_LAT))
      else $error("result beat without a query");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_point_x == {1'b0, {(COORD_W-1){1'b1}}} ||
          rsp_point_x == {1'b1, {(COORD_W-1){1'b0}}} ||
          rsp_point_y == {1'b0, {(COORD_W-1){1'b1}}} ||
          rsp_point_y == {1'b1, {(COORD_W-1){1'b0}}} ||
          rsp_point_z == {1'b0, {(COORD_W-1){1'b1}}} ||
          rsp_point_z == {1'b1, {(COORD_W-1){1'b0}}}))
      else $error("saturation flag without a clamped coordinate");

endmodule

>>> rtl/obsp_rotate.sv
// ============================================================================
// obsp_rotate
// Builds the rotation matrix from the quaternion and produces the eight
// rotated, translated box corners. Four register stages.
// ============================================================================
module obsp_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  obsp_pkg::coord_type dir_in  [3],
   input  obsp_pkg::coord_type pos_in  [3],
   input  obsp_pkg::quat_type  rot_w,
   input  obsp_pkg::quat_type  rot_x,
   input  obsp_pkg::quat_type  rot_y,
   input  obsp_pkg::quat_type  rot_z,
   input  obsp_pkg::coord_type box_lo  [3],
   input  obsp_pkg::coord_type box_hi  [3],
   output logic               out_valid,
   output obsp_pkg::coord_type dir_out [3],
   output obsp_pkg::crn_type   crn_out [obsp_pkg::NUM_CRN][3]
);
   import obsp_pkg::*;

   // Round half up and drop 16 fraction bits
   function automatic mat_type round_mat(input logic signed [MSUM_W-1:0] v);
      logic signed [MSUM_W-1:0] t;
      t = v + MSUM_W'(32768);
      return MAT_W'(t >>> 16);
   endfunction

   logic [ROT_LAT-1:0] vld_ff;
   coord_type          dir_pipe_ff [ROT_LAT][3];
   coord_type          pos_pipe_ff [ROT_LAT-1][3];

   // valid and sideband pipes
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ROT_LAT-2:0], in_valid};
      end
      dir_pipe_ff[0] <= dir_in;
      pos_pipe_ff[0] <= pos_in;
      for (int s = 1; s < ROT_LAT; s++) begin
         dir_pipe_ff[s] <= dir_pipe_ff[s-1];
      end
      for (int s = 1; s < ROT_LAT - 1; s++) begin
         pos_pipe_ff[s] <= pos_pipe_ff[s-1];
      end
   end

   // stage 1: quaternion part products
   logic signed [QPROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff;
   logic signed [QPROD_W-1:0] wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;

   always_ff @(posedge clock) begin
      ww_ff <= rot_w * rot_w;
      xx_ff <= rot_x * rot_x;
      yy_ff <= rot_y * rot_y;
      zz_ff <= rot_z * rot_z;
      xy_ff <= rot_x * rot_y;
      wz_ff <= rot_w * rot_z;
      xz_ff <= rot_x * rot_z;
      wy_ff <= rot_w * rot_y;
      yz_ff <= rot_y * rot_z;
      wx_ff <= rot_w * rot_x;
   end

   // stage 2: matrix entries
   logic signed [MSUM_W-1:0] msum [3][3];
   mat_type                  m_ff [3][3];

   always_comb begin
      msum[0][0] = MSUM_W'(ww_ff) + MSUM_W'(xx_ff) - MSUM_W'(yy_ff) - MSUM_W'(zz_ff);
      msum[1][1] = MSUM_W'(ww_ff) - MSUM_W'(xx_ff) + MSUM_W'(yy_ff) - MSUM_W'(zz_ff);
      msum[2][2] = MSUM_W'(ww_ff) - MSUM_W'(xx_ff) - MSUM_W'(yy_ff) + MSUM_W'(zz_ff);
      msum[0][1] = (MSUM_W'(xy_ff) - MSUM_W'(wz_ff)) <<< 1;
      msum[0][2] = (MSUM_W'(xz_ff) + MSUM_W'(wy_ff)) <<< 1;
      msum[1][0] = (MSUM_W'(xy_ff) + MSUM_W'(wz_ff)) <<< 1;
      msum[1][2] = (MSUM_W'(yz_ff) - MSUM_W'(wx_ff)) <<< 1;
      msum[2][0] = (MSUM_W'(xz_ff) - MSUM_W'(wy_ff)) <<< 1;
      msum[2][1] = (MSUM_W'(yz_ff) + MSUM_W'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m_ff[i][j] <= round_mat(msum[i][j]);
         end
      end
   end

   // stage 3: matrix entries times both box bounds
   logic signed [MPROD_W-1:0] plo_ff [3][3];
   logic signed [MPROD_W-1:0] phi_ff [3][3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            plo_ff[i][j] <= m_ff[i][j] * box_lo[j];
            phi_ff[i][j] <= m_ff[i][j] * box_hi[j];
         end
      end
   end

   // stage 4: pick bounds per corner, round, add position
   logic signed [ACC_W-1:0] acc;
   crn_type                 crn_in [NUM_CRN][3];
   crn_type                 crn_ff [NUM_CRN][3];

   always_comb begin
      acc = '0;
      for (int k = 0; k < NUM_CRN; k++) begin
         for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
               acc = acc + (CRN_SEL[k][j] ? ACC_W'(phi_ff[i][j]) : ACC_W'(plo_ff[i][j]));
            end
            crn_in[k][i] = CRN_W'((acc + ACC_W'(32768)) >>> 16)
                         + CRN_W'(pos_pipe_ff[ROT_LAT-2][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      crn_ff <= crn_in;
   end

   assign out_valid = vld_ff[ROT_LAT-1];
   assign dir_out   = dir_pipe_ff[ROT_LAT-1];
   assign crn_out   = crn_ff;

endmodule

>>> rtl/obsp_select.sv
// ============================================================================
// obsp_select
// Exact dot product of each corner with the search direction, then a
// registered three-level tree that keeps the largest, earliest on a tie.
// Six register stages.
// ============================================================================
module obsp_select (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  obsp_pkg::coord_type dir_in [3],
   input  obsp_pkg::crn_type   crn_in [obsp_pkg::NUM_CRN][3],
   output logic               out_valid,
   output obsp_pkg::crn_type   best_out [3]
);
   import obsp_pkg::*;

   logic [SEL_LAT-1:0] vld_ff;
   crn_type            crn_pipe_ff [3][NUM_CRN][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[SEL_LAT-2:0], in_valid};
      end
      crn_pipe_ff[0] <= crn_in;
      crn_pipe_ff[1] <= crn_pipe_ff[0];
      crn_pipe_ff[2] <= crn_pipe_ff[1];
   end

   // stage 1: split each corner coordinate and multiply by the direction
   logic signed [PLO_W-1:0] plo_ff [NUM_CRN][3];
   logic signed [PHI_W-1:0] phi_ff [NUM_CRN][3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CRN; k++) begin
         for (int i = 0; i < 3; i++) begin
            plo_ff[k][i] <= dir_in[i] * $signed({1'b0, crn_in[k][i][CLO_W-1:0]});
            phi_ff[k][i] <= dir_in[i] * $signed(crn_in[k][i][CRN_W-1:CLO_W]);
         end
      end
   end

   // stage 2: join the slices per axis
   logic signed [TERM_W-1:0] term_ff [NUM_CRN][3];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CRN; k++) begin
         for (int i = 0; i < 3; i++) begin
            term_ff[k][i] <= (TERM_W'(phi_ff[k][i]) <<< CLO_W) + TERM_W'(plo_ff[k][i]);
         end
      end
   end

   // stage 3: sum over axes
   dot_type dot_ff [NUM_CRN];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CRN; k++) begin
         dot_ff[k] <= DOT_W'(term_ff[k][0]) + DOT_W'(term_ff[k][1]) + DOT_W'(term_ff[k][2]);
      end
   end

   // stages 4 to 6: max tree, left side wins a tie
   dot_type l1_dot_ff [4];
   crn_type l1_crn_ff [4][3];
   dot_type l2_dot_ff [2];
   crn_type l2_crn_ff [2][3];
   crn_type best_ff   [3];

   always_ff @(posedge clock) begin
      for (int n = 0; n < 4; n++) begin
         if (dot_ff[2*n+1] > dot_ff[2*n]) begin
            l1_dot_ff[n] <= dot_ff[2*n+1];
            l1_crn_ff[n] <= crn_pipe_ff[2][2*n+1];
         end else begin
            l1_dot_ff[n] <= dot_ff[2*n];
            l1_crn_ff[n] <= crn_pipe_ff[2][2*n];
         end
      end
      for (int n = 0; n < 2; n++) begin
         if (l1_dot_ff[2*n+1] > l1_dot_ff[2*n]) begin
            l2_dot_ff[n] <= l1_dot_ff[2*n+1];
            l2_crn_ff[n] <= l1_crn_ff[2*n+1];
         end else begin
            l2_dot_ff[n] <= l1_dot_ff[2*n];
            l2_crn_ff[n] <= l1_crn_ff[2*n];
         end
      end
      if (l2_dot_ff[1] > l2_dot_ff[0]) begin
         best_ff <= l2_crn_ff[1];
      end else begin
         best_ff <= l2_crn_ff[0];
      end
   end

   assign out_valid = vld_ff[SEL_LAT-1];
   assign best_out  = best_ff;

endmodule

>>> rtl/obsp_offset.sv
// ============================================================================
// obsp_offset
// Push-out offset: normalizes the direction magnitudes, takes the integer
// square root of their squared length and divides |d|*|bias| by it, all
// pipelined one result per cycle.
// ============================================================================
module obsp_offset (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  obsp_pkg::coord_type dir_in [3],
   input  obsp_pkg::coord_type bias_in,
   output logic               out_valid,
   output obsp_pkg::off_type   off_out [3]
);
   import obsp_pkg::*;

   // stage 1: magnitudes, largest magnitude, result signs
   logic [MAG_W-1:0] mag_c [3];
   logic [MAG_W-1:0] mx1_in;
   logic [MAG_W-1:0] mag1_ff [3];
   logic [MAG_W-1:0] mx1_ff, bm1_ff;
   logic [2:0]       neg1_ff;
   logic             v1_ff;

   always_comb begin
      mx1_in = '0;
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = dir_in[i][COORD_W-1] ? MAG_W'(-dir_in[i]) : MAG_W'(dir_in[i]);
         if (mag_c[i] > mx1_in) begin
            mx1_in = mag_c[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      mag1_ff <= mag_c;
      mx1_ff  <= mx1_in;
      bm1_ff  <= bias_in[COORD_W-1] ? MAG_W'(-bias_in) : MAG_W'(bias_in);
      for (int i = 0; i < 3; i++) begin
         neg1_ff[i] <= dir_in[i][COORD_W-1] ^ bias_in[COORD_W-1];
      end
   end

   // stage 2: normalizing shift amount
   logic [SHIFT_W-1:0] msb;
   logic [SHIFT_W-1:0] sh2_ff;
   logic [MAG_W-1:0]   mag2_ff [3];
   logic [MAG_W-1:0]   bm2_ff;
   logic [2:0]         neg2_ff;
   logic               zero2_ff, v2_ff;

   always_comb begin
      msb = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (mx1_ff[b]) begin
            msb = SHIFT_W'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      sh2_ff   <= (msb >= SHIFT_W'(NORM_MSB)) ? '0 : SHIFT_W'(NORM_MSB) - msb;
      zero2_ff <= (mx1_ff == '0);
      mag2_ff  <= mag1_ff;
      bm2_ff   <= bm1_ff;
      neg2_ff  <= neg1_ff;
   end

   // stage 3: shift all magnitudes together
   logic [MAG_W-1:0] mag3_ff [3];
   logic [MAG_W-1:0] bm3_ff;
   logic [2:0]       neg3_ff;
   logic             zero3_ff, v3_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag3_ff[i] <= mag2_ff[i] << sh2_ff;
      end
      bm3_ff   <= bm2_ff;
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
   end

   // stage 4: squares and bias products
   logic [SQ_W-1:0] sq4_ff [3];
   logic [SQ_W-1:0] prd4_ff [3];
   logic [2:0]      neg4_ff;
   logic            zero4_ff, v4_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq4_ff[i]  <= SQ_W'(mag3_ff[i]) * SQ_W'(mag3_ff[i]);
         prd4_ff[i] <= SQ_W'(mag3_ff[i]) * SQ_W'(bm3_ff);
      end
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;
   end

   // stage 5 and square root stages: two root bits per stage
   sqrt_type      sqp_in [SQRT_STAGES+1];
   sqrt_type      sqp_ff [SQRT_STAGES+1];
   sqrt_side_type sqs_ff [SQRT_STAGES+1];
   logic [SQRT_STAGES:0] sqv_ff;

   always_comb begin
      sqp_in[0].n    = sq4_ff[0] + sq4_ff[1] + sq4_ff[2];
      sqp_in[0].rem  = '0;
      sqp_in[0].root = '0;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         sqp_in[s+1] = sqp_ff[s];
         for (int t = 0; t < SQRT_STEPS; t++) begin
            sqp_in[s+1].rem = {sqp_in[s+1].rem[SQRT_REM_W-3:0], sqp_in[s+1].n[SQ_W-1 -: 2]};
            sqp_in[s+1].n   = {sqp_in[s+1].n[SQ_W-3:0], 2'b00};
            if (sqp_in[s+1].rem >= SQRT_REM_W'({sqp_in[s+1].root, 2'b01})) begin
               sqp_in[s+1].rem  = sqp_in[s+1].rem - SQRT_REM_W'({sqp_in[s+1].root, 2'b01});
               sqp_in[s+1].root = {sqp_in[s+1].root[ROOT_W-2:0], 1'b1};
            end else begin
               sqp_in[s+1].root = {sqp_in[s+1].root[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sqp_ff <= sqp_in;
      sqs_ff[0].zero <= zero4_ff;
      sqs_ff[0].neg  <= neg4_ff;
      for (int i = 0; i < 3; i++) begin
         sqs_ff[0].prd[i] <= prd4_ff[i];
      end
      for (int s = 1; s <= SQRT_STAGES; s++) begin
         sqs_ff[s] <= sqs_ff[s-1];
      end
   end

   // numerator stage and divider stages: four quotient bits per stage
   logic [SQ_W-1:0] num [3];
   logic [QUOT_W:0] trial;
   div_type         dvp_in [DIV_STAGES+1][3];
   div_type         dvp_ff [DIV_STAGES+1][3];
   div_side_type    dvs_ff [DIV_STAGES+1];
   logic [DIV_STAGES:0] dvv_ff;

   always_comb begin
      trial = '0;
      for (int l = 0; l < 3; l++) begin
         num[l] = sqs_ff[SQRT_STAGES].prd[l] + SQ_W'(sqp_ff[SQRT_STAGES].root >> 1);
         dvp_in[0][l].rem = num[l][SQ_W-1:QUOT_W];
         dvp_in[0][l].q   = '0;
         dvp_in[0][l].nb  = num[l][QUOT_W-1:0];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            dvp_in[s+1][l] = dvp_ff[s][l];
            for (int t = 0; t < DIV_STEPS; t++) begin
               trial = {dvp_in[s+1][l].rem, dvp_in[s+1][l].nb[QUOT_W-1]};
               dvp_in[s+1][l].nb = {dvp_in[s+1][l].nb[QUOT_W-2:0], 1'b0};
               if (trial >= {1'b0, dvs_ff[s].len}) begin
                  dvp_in[s+1][l].rem = QUOT_W'(trial - {1'b0, dvs_ff[s].len});
                  dvp_in[s+1][l].q   = {dvp_in[s+1][l].q[QUOT_W-2:0], 1'b1};
               end else begin
                  dvp_in[s+1][l].rem = trial[QUOT_W-1:0];
                  dvp_in[s+1][l].q   = {dvp_in[s+1][l].q[QUOT_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dvp_ff <= dvp_in;
      dvs_ff[0].zero <= sqs_ff[SQRT_STAGES].zero;
      dvs_ff[0].neg  <= sqs_ff[SQRT_STAGES].neg;
      dvs_ff[0].len  <= sqp_ff[SQRT_STAGES].root;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         dvs_ff[s] <= dvs_ff[s-1];
      end
   end

   // final stage: sign, zero direction gives no offset
   off_type off_ff [3];
   logic    vo_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         if (dvs_ff[DIV_STAGES].zero) begin
            off_ff[l] <= '0;
         end else if (dvs_ff[DIV_STAGES].neg[l]) begin
            off_ff[l] <= -$signed({2'b00, dvp_ff[DIV_STAGES][l].q});
         end else begin
            off_ff[l] <= $signed({2'b00, dvp_ff[DIV_STAGES][l].q});
         end
      end
   end

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         sqv_ff <= '0;
         dvv_ff <= '0;
         vo_ff  <= 1'b0;
      end else begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         sqv_ff <= {sqv_ff[SQRT_STAGES-1:0], v4_ff};
         dvv_ff <= {dvv_ff[DIV_STAGES-1:0], sqv_ff[SQRT_STAGES]};
         vo_ff  <= dvv_ff[DIV_STAGES];
      end
   end

   assign out_valid = vo_ff;
   assign off_out   = off_ff;

endmodule

>>> verif/obsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsp_checker
// Watches the query, result and register channels of the support point unit,
// predicts each query's support point and compares every result beat.
// ----------------------------------------------------------------------------
module obsp_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  obsp_pkg::coord_type req_dir_x,
   input  obsp_pkg::coord_type req_dir_y,
   input  obsp_pkg::coord_type req_dir_z,
   input  obsp_pkg::coord_type req_pos_x,
   input  obsp_pkg::coord_type req_pos_y,
   input  obsp_pkg::coord_type req_pos_z,
   input  obsp_pkg::quat_type  req_rot_w,
   input  obsp_pkg::quat_type  req_rot_x,
   input  obsp_pkg::quat_type  req_rot_y,
   input  obsp_pkg::quat_type  req_rot_z,
   input  obsp_pkg::coord_type req_bias,
   input  logic                rsp_strobe,
   input  obsp_pkg::coord_type rsp_point_x,
   input  obsp_pkg::coord_type rsp_point_y,
   input  obsp_pkg::coord_type rsp_point_z,
   input  logic                rsp_saturated,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  obsp_pkg::coord_type csr_wdata,
   output int                  fail_count,
   output int                  pending_points
);
   import obsp_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      sat;
   } point_type;

   point_type expected_points[$];
   longint    box_min_reg[3];
   longint    box_max_reg[3];

   assign pending_points = expected_points.size();

   initial fail_count = 0;

   // round half up at bit s
   function automatic wide_type round_shift(wide_type v, int s);
      round_shift = (v + (wide_type'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      int_sqrt = r;
   endfunction

   // support point of the current box for one query
   function automatic point_type support_point(
      coord_type dx, coord_type dy, coord_type dz,
      coord_type px, coord_type py, coord_type pz,
      quat_type qw, quat_type qx, quat_type qy, quat_type qz, coord_type bias);
      wide_type    d[3], p[3], m[3][3], c[3], best[3], v[3];
      wide_type    w, x, y, z, acc, dot, best_dot, off, r;
      logic [63:0] mag[3], mx, bm, sq, len;
      point_type   res;
      d[0] = dx; d[1] = dy; d[2] = dz;
      p[0] = px; p[1] = py; p[2] = pz;
      w = qw; x = qx; y = qy; z = qz;
      m[0][0] = round_shift(w*w + x*x - y*y - z*z, 16);
      m[0][1] = round_shift(2*(x*y - w*z), 16);
      m[0][2] = round_shift(2*(x*z + w*y), 16);
      m[1][0] = round_shift(2*(x*y + w*z), 16);
      m[1][1] = round_shift(w*w - x*x + y*y - z*z, 16);
      m[1][2] = round_shift(2*(y*z - w*x), 16);
      m[2][0] = round_shift(2*(x*z - w*y), 16);
      m[2][1] = round_shift(2*(y*z + w*x), 16);
      m[2][2] = round_shift(w*w - x*x - y*y + z*z, 16);
      best_dot = 0;
      for (int i = 0; i < 3; i++) best[i] = 0;
      // rotate each corner, keep the first with the largest dot product
      for (int k = 0; k < NUM_CRN; k++) begin
         for (int i = 0; i < 3; i++)
            v[i] = CRN_SEL[k][i] ? box_max_reg[i] : box_min_reg[i];
         dot = 0;
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc = acc + m[i][j] * v[j];
            c[i] = round_shift(acc, 16) + p[i];
            dot = dot + d[i] * c[i];
         end
         if (k == 0 || dot > best_dot) begin
            best_dot = dot;
            for (int i = 0; i < 3; i++) best[i] = c[i];
         end
      end
      // push out along the normalized direction
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
         if (mag[i] > mx) mx = mag[i];
      end
      bm = bias < 0 ? 64'(-wide_type'(bias)) : 64'(bias);
      if (mx != 0) begin
         while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         sq = 0;
         for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
         len = int_sqrt(sq);
         for (int i = 0; i < 3; i++) begin
            off = {64'd0, (mag[i] * bm + len / 2) / len};
            if ((d[i] < 0) != (bias < 0)) off = -off;
            best[i] = best[i] + off;
         end
      end
      // clamp to 32 bits
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         r = best[i];
         if (r > 2147483647) begin
            r = 2147483647;
            res.sat = 1'b1;
         end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            res.sat = 1'b1;
         end
         best[i] = r;
      end
      res.x = best[0][31:0];
      res.y = best[1][31:0];
      res.z = best[2][31:0];
      support_point = res;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // register shadow, prediction and comparison
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_min_reg[i] = 0;
            box_max_reg[i] = 0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BOX_MIN_X: box_min_reg[0] = csr_wdata;
               CSR_BOX_MIN_Y: box_min_reg[1] = csr_wdata;
               CSR_BOX_MIN_Z: box_min_reg[2] = csr_wdata;
               CSR_BOX_MAX_X: box_max_reg[0] = csr_wdata;
               CSR_BOX_MAX_Y: box_max_reg[1] = csr_wdata;
               CSR_BOX_MAX_Z: box_max_reg[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_points.size() == 0) begin
               report("unexpected result beat", 1, 0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_point_x !== want.x) report("point_x", rsp_point_x, want.x);
               if (rsp_point_y !== want.y) report("point_y", rsp_point_y, want.y);
               if (rsp_point_z !== want.z) report("point_z", rsp_point_z, want.z);
               if (rsp_saturated !== want.sat) report("saturated", rsp_saturated, want.sat);
            end
         end
         if (start && !busy)
            expected_points.insert(expected_points.size(),
               support_point(req_dir_x, req_dir_y, req_dir_z,
               req_pos_x, req_pos_y, req_pos_z, req_rot_w, req_rot_x, req_rot_y,
               req_rot_z, req_bias));
      end
   end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives box settings and query beats into the support point unit in phases
// with different idle patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
   import obsp_pkg::*;

   localparam logic [2:0] CSR_UNMAPPED = 3'd6;
   localparam int         ITEMS_PER_PHASE = 115;
   localparam int         NUM_PHASES = 6;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   coord_type  req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   coord_type  req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   quat_type   req_rot_w = '0, req_rot_x = '0, req_rot_y = '0, req_rot_z = '0;
   coord_type  req_bias = '0;
   logic       rsp_strobe;
   coord_type  rsp_point_x, rsp_point_y, rsp_point_z;
   logic       rsp_saturated;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   coord_type  csr_wdata = '0;
   int         fail_count;
   int         pending_points;
   int         idle_pct;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   oriented_box_support_point_unit uut (.*);

   obsp_checker u_checker (.*);

   // register write beat; the caller drops csr_valid after the last one
   task automatic write_csr(logic [2:0] idx, coord_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_box(coord_type x0, coord_type y0, coord_type z0,
                           coord_type x1, coord_type y1, coord_type z1);
      write_csr(CSR_BOX_MIN_X, x0);
      write_csr(CSR_BOX_MIN_Y, y0);
      write_csr(CSR_BOX_MIN_Z, z0);
      write_csr(CSR_BOX_MAX_X, x1);
      write_csr(CSR_BOX_MAX_Y, y1);
      write_csr(CSR_BOX_MAX_Z, z1);
      csr_valid <= 1'b0;
   endtask

   // one query beat, with a random gap before it in idle_pct percent of calls
   task automatic send_query(coord_type dx, coord_type dy, coord_type dz,
                             coord_type px, coord_type py, coord_type pz,
                             quat_type qw, quat_type qx, quat_type qy, quat_type qz,
                             coord_type b);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start     <= 1'b1;
      req_dir_x <= dx; req_dir_y <= dy; req_dir_z <= dz;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_rot_w <= qw; req_rot_x <= qx; req_rot_y <= qy; req_rot_z <= qz;
      req_bias  <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0:       rand_coord = 0;
         1:       rand_coord = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2, 3:    rand_coord = $signed($urandom_range(0, 2097152)) - 1048576;
         default: rand_coord = $urandom;
      endcase
   endfunction

   function automatic quat_type rand_quat_part();
      rand_quat_part = $signed($urandom_range(0, 131072)) - 65536;
   endfunction

   // mostly unit quaternions, some raw ones
   task automatic send_random();
      real       a[4];
      real       n;
      quat_type  q[4];
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         a[i] = $itor($signed($urandom_range(0, 2000)) - 1000);
         n = n + a[i] * a[i];
      end
      if ($urandom_range(9) < 7 && n > 0.0) begin
         for (int i = 0; i < 4; i++) q[i] = $rtoi(a[i] / $sqrt(n) * 65536.0);
      end else begin
         for (int i = 0; i < 4; i++) q[i] = rand_quat_part();
      end
      send_query(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(),
                 q[0], q[1], q[2], q[3], rand_coord());
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_points != 0) @(posedge clock);
   endtask

   // stimulus and verdict
   initial begin
      idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // dropped index, then a small box
      write_csr(CSR_UNMAPPED, 32'h1234_5678);
      load_box(-32'sd65536, -32'sd131072, -32'sd196608,
               32'sd65536, 32'sd131072, 32'sd196608);
      // directed queries
      send_query(0, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 65536);
      send_query(65536, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0);
      send_query(0, -65536, 0, 100, 200, 300, 65536, 0, 0, 0, 32768);
      send_query(0, 0, 65536, 0, 0, 0, 46341, 46341, 0, 0, -65536);
      send_query(65536, 65536, 65536, 0, 0, 0, 0, 65536, 0, 0, 65536);
      send_query(-65536, 65536, -65536, 0, 0, 0, 0, 0, 65536, 0, 65536);
      send_query(1, 1, 0, 0, 0, 0, 0, 0, 0, 65536, 65536);
      send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 65536, 0, 0, 0, 32'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 -65536, 0, 0, 0, 32'h8000_0000);
      send_query(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 0,
                 65536, 65536, 65536, 65536, 32'h7FFF_FFFF);
      send_query(-1, -1, -1, 0, 0, 0, -65536, -65536, -65536, -65536, -1);
      send_query(65536, 0, 0, 32'h7FFF_0000, 0, 0, 65536, 0, 0, 0, 32'h0100_0000);
      send_query(0, 65536, 0, 0, 32'h8001_0000, 0, 65536, 0, 0, 0, 32'h8000_0000);
      send_query(0, 0, 0, 5, 6, 7, 12345, -23456, 34567, -45678, 32'h7FFF_FFFF);
      send_query(3, -7, 11, 0, 0, 0, 0, 0, 0, 0, 65536);
      send_query(65536, 65536, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      drain();
      // phases of box settings and idle patterns
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 49;
            2: idle_pct = 14;
            3: idle_pct = 0;
            4: idle_pct = 49;
            default: idle_pct = 14;
         endcase
         case (ph)
            0: load_box(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
            1: load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            2: load_box(0, 0, 0, 0, 0, 0);
            // min above max
            3: load_box(32'sd300000, 32'sd200000, 32'sd100000,
                        -32'sd100000, -32'sd200000, -32'sd300000);
            4: load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: load_box(-32'sd4096, -32'sd8192, -32'sd16384,
                              32'sd16384, 32'sd8192, 32'sd4096);
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
         drain();
      end
      repeat (RSP_LAT + 8) @(posedge clock);
      if (fail_count == 0 && pending_points == 0) begin
         $display("PASS oriented_box_support_point_unit");
      end else begin
         $display("FAIL oriented_box_support_point_unit");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("FAIL oriented_box_support_point_unit");
      $finish;
   end

endmodule
